// ----- rtl/kle_pkg.sv -----
// Shared types and constants for the keystroke line editor.
// Request and result structs, microcode word layout and step addresses.
// No dependencies.
package kle_pkg;

  // Field widths fixed by the request and result formats
  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 10;
  localparam int unsigned LenW  = 11;
  localparam int unsigned ReqW  = 2;

  // Default store depth
  localparam int unsigned DepthDefault = 1024;

  // Request type codes
  localparam logic [ReqW-1:0] ReqKey   = 2'd0;
  localparam logic [ReqW-1:0] ReqRead  = 2'd1;
  localparam logic [ReqW-1:0] ReqClear = 2'd2;

  // Special keystrokes
  localparam logic [CharW-1:0] KeyLeft  = 8'd60;
  localparam logic [CharW-1:0] KeyRight = 8'd62;
  localparam logic [CharW-1:0] KeyBack  = 8'd45;

  // Microcode step addresses
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] StFetch   = 4'd0;
  localparam logic [StepW-1:0] StDone    = 4'd1;
  localparam logic [StepW-1:0] StLeftChk = 4'd2;
  localparam logic [StepW-1:0] StLeftRd  = 4'd3;
  localparam logic [StepW-1:0] StLeftWr  = 4'd4;
  localparam logic [StepW-1:0] StRightChk = 4'd5;
  localparam logic [StepW-1:0] StRightRd = 4'd6;
  localparam logic [StepW-1:0] StRightWr = 4'd7;
  localparam logic [StepW-1:0] StBackChk = 4'd8;
  localparam logic [StepW-1:0] StBackDec = 4'd9;
  localparam logic [StepW-1:0] StInsChk  = 4'd10;
  localparam logic [StepW-1:0] StInsWr   = 4'd11;
  localparam logic [StepW-1:0] StOvf     = 4'd12;
  localparam logic [StepW-1:0] StReadChk = 4'd13;
  localparam logic [StepW-1:0] StReadRd  = 4'd14;
  localparam logic [StepW-1:0] StClear   = 4'd15;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [CharW-1:0] key_byte;
    logic [PosW-1:0]  read_position;
  } kle_req_t;

  typedef struct packed {
    logic [CharW-1:0] read_char;
    logic             in_range;
    logic [LenW-1:0]  line_length;
    logic [LenW-1:0]  cursor_position;
    logic             overflow;
  } kle_rsp_t;

  // Next-step selection
  typedef enum logic [2:0] {
    JC_NEXT       = 3'd0,
    JC_ALWAYS     = 3'd1,
    JC_DISPATCH   = 3'd2,
    JC_LEFT_ZERO  = 3'd3,
    JC_RIGHT_ZERO = 3'd4,
    JC_FULL       = 3'd5,
    JC_OUT_RANGE  = 3'd6
  } jump_cond_e;

  // Store address source
  typedef enum logic [1:0] {
    AS_LEFT    = 2'd0,
    AS_LEFT_M1 = 2'd1,
    AS_TOP     = 2'd2,
    AS_READ    = 2'd3
  } addr_sel_e;

  // Count update
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  // Store write data source
  typedef enum logic {
    WS_KEY   = 1'b0,
    WS_RDATA = 1'b1
  } wdata_sel_e;

  typedef struct packed {
    jump_cond_e       jc;
    logic [StepW-1:0] target;
    logic             wait_in;
    logic             wait_out;
    logic             out_ld;
    logic             mem_re;
    logic             mem_we;
    wdata_sel_e       wsel;
    addr_sel_e        asel;
    cnt_op_e          left_op;
    cnt_op_e          right_op;
    logic             set_ovf;
    logic             set_inr;
  } uword_t;

  // Sequencer to datapath: current control word and its advance strobe
  typedef struct packed {
    logic   go;
    uword_t uw;
  } ctrl_t;

  // Datapath to sequencer: jump conditions and output stall
  typedef struct packed {
    logic left_zero;
    logic right_zero;
    logic full;
    logic out_range;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/kle_useq.sv -----
// Microcode sequencer for the keystroke line editor: step counter,
// control store and jump logic. Depends on kle_pkg.
module kle_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  kle_pkg::kle_req_t in_req_i,
  input  kle_pkg::status_t  status_i,
  output logic              in_ready_o,
  output kle_pkg::ctrl_t    ctrl_o
);
  import kle_pkg::*;

  // Control store: one word per step
  function automatic uword_t ucode(logic [StepW-1:0] step);
    uword_t w;
    w = '0;
    case (step)
      StFetch: begin
        w.wait_in = 1'b1;
        w.jc      = JC_DISPATCH;
      end
      StDone: begin
        w.wait_out = 1'b1;
        w.out_ld   = 1'b1;
        w.jc       = JC_ALWAYS;
        w.target   = StFetch;
      end
      StLeftChk: begin
        w.jc     = JC_LEFT_ZERO;
        w.target = StDone;
      end
      StLeftRd: begin
        w.mem_re   = 1'b1;
        w.asel     = AS_LEFT_M1;
        w.left_op  = CNT_DEC;
        w.right_op = CNT_INC;
      end
      StLeftWr: begin
        w.mem_we = 1'b1;
        w.wsel   = WS_RDATA;
        w.asel   = AS_TOP;
        w.jc     = JC_ALWAYS;
        w.target = StDone;
      end
      StRightChk: begin
        w.jc     = JC_RIGHT_ZERO;
        w.target = StDone;
      end
      StRightRd: begin
        w.mem_re = 1'b1;
        w.asel   = AS_TOP;
      end
      StRightWr: begin
        w.mem_we   = 1'b1;
        w.wsel     = WS_RDATA;
        w.asel     = AS_LEFT;
        w.left_op  = CNT_INC;
        w.right_op = CNT_DEC;
        w.jc       = JC_ALWAYS;
        w.target   = StDone;
      end
      StBackChk: begin
        w.jc     = JC_LEFT_ZERO;
        w.target = StDone;
      end
      StBackDec: begin
        w.left_op = CNT_DEC;
        w.jc      = JC_ALWAYS;
        w.target  = StDone;
      end
      StInsChk: begin
        w.jc     = JC_FULL;
        w.target = StOvf;
      end
      StInsWr: begin
        w.mem_we  = 1'b1;
        w.wsel    = WS_KEY;
        w.asel    = AS_LEFT;
        w.left_op = CNT_INC;
        w.jc      = JC_ALWAYS;
        w.target  = StDone;
      end
      StOvf: begin
        w.set_ovf = 1'b1;
        w.jc      = JC_ALWAYS;
        w.target  = StDone;
      end
      StReadChk: begin
        w.jc     = JC_OUT_RANGE;
        w.target = StDone;
      end
      StReadRd: begin
        w.mem_re  = 1'b1;
        w.asel    = AS_READ;
        w.set_inr = 1'b1;
        w.jc      = JC_ALWAYS;
        w.target  = StDone;
      end
      StClear: begin
        w.left_op  = CNT_CLR;
        w.right_op = CNT_CLR;
        w.jc       = JC_ALWAYS;
        w.target   = StDone;
      end
      default: begin
        w.jc     = JC_ALWAYS;
        w.target = StFetch;
      end
    endcase
    return w;
  endfunction

  // Routine entry for an incoming request
  function automatic logic [StepW-1:0] entry(kle_req_t r);
    logic [StepW-1:0] s;
    s = StDone;
    case (r.req_type)
      ReqKey: begin
        if (r.key_byte == KeyLeft) begin
          s = StLeftChk;
        end else if (r.key_byte == KeyRight) begin
          s = StRightChk;
        end else if (r.key_byte == KeyBack) begin
          s = StBackChk;
        end else begin
          s = StInsChk;
        end
      end
      ReqRead:  s = StReadChk;
      ReqClear: s = StClear;
      default:  s = StDone;
    endcase
    return s;
  endfunction

  logic [StepW-1:0] step_q, step_d;
  uword_t           uw;
  logic             go;
  logic             taken;

  // Decode the current step
  always_comb begin
    uw = ucode(step_q);
    go = !((uw.wait_in && !in_valid_i) || (uw.wait_out && status_i.out_busy));
    case (uw.jc)
      JC_ALWAYS:     taken = 1'b1;
      JC_DISPATCH:   taken = 1'b1;
      JC_LEFT_ZERO:  taken = status_i.left_zero;
      JC_RIGHT_ZERO: taken = status_i.right_zero;
      JC_FULL:       taken = status_i.full;
      JC_OUT_RANGE:  taken = status_i.out_range;
      default:       taken = 1'b0;
    endcase
  end

  // Pick the next step
  always_comb begin
    step_d = step_q;
    if (go) begin
      if (uw.jc == JC_DISPATCH) begin
        step_d = entry(in_req_i);
      end else if (taken) begin
        step_d = uw.target;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StFetch;
    end else begin
      step_q <= step_d;
    end
  end

  assign in_ready_o = (step_q == StFetch);
  assign ctrl_o     = '{go: go, uw: uw};

endmodule

// ----- rtl/kle_dpath.sv -----
// Datapath for the keystroke line editor: gap buffer store, left and right
// counts, address generation and result register. Depends on kle_pkg.
module kle_dpath #(
  parameter int unsigned Depth = kle_pkg::DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kle_pkg::ctrl_t    ctrl_i,
  input  kle_pkg::kle_req_t in_req_i,
  output kle_pkg::status_t  status_o,
  output kle_pkg::kle_rsp_t out_req_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import kle_pkg::*;

  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned OutW  = (CntW > LenW) ? CntW : LenW;

  logic [CharW-1:0] mem_q [Depth];
  logic [CharW-1:0] rdata_q;
  logic [CntW-1:0]  left_q, left_d, right_q, right_d;
  kle_req_t         item_q;
  logic             ovf_q, ovf_d, inr_q, inr_d;
  kle_rsp_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [CntW-1:0]  len;
  logic [CntW-1:0]  top;
  logic [CmpW-1:0]  pos_c, len_c, left_c, right_c, rd_idx;
  logic [AddrW-1:0] addr;
  logic [CharW-1:0] wdata;
  logic             latch, do_we, do_re, load;

  // Line length, store top and read index
  always_comb begin
    len     = left_q + right_q;
    top     = CntW'(Depth) - right_q;
    pos_c   = CmpW'(item_q.read_position);
    len_c   = CmpW'(len);
    left_c  = CmpW'(left_q);
    right_c = CmpW'(right_q);
    if (pos_c < left_c) begin
      rd_idx = pos_c;
    end else begin
      rd_idx = CmpW'(Depth) - right_c + (pos_c - left_c);
    end
  end

  // Select the store address
  always_comb begin
    case (ctrl_i.uw.asel)
      AS_LEFT:    addr = AddrW'(left_q);
      AS_LEFT_M1: addr = AddrW'(left_q - CntW'(1));
      AS_TOP:     addr = AddrW'(top);
      AS_READ:    addr = AddrW'(rd_idx);
      default:    addr = AddrW'(left_q);
    endcase
    wdata = (ctrl_i.uw.wsel == WS_RDATA) ? rdata_q : item_q.key_byte;
    latch = ctrl_i.go && ctrl_i.uw.wait_in;
    do_we = ctrl_i.go && ctrl_i.uw.mem_we;
    do_re = ctrl_i.go && ctrl_i.uw.mem_re;
    load  = ctrl_i.go && ctrl_i.uw.out_ld;
  end

  // Single-port store with registered read
  always_ff @(posedge clk_i) begin
    if (do_we) begin
      mem_q[addr] <= wdata;
    end
    if (do_re) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Update counts
  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (ctrl_i.go) begin
      case (ctrl_i.uw.left_op)
        CNT_INC: left_d = left_q + CntW'(1);
        CNT_DEC: left_d = left_q - CntW'(1);
        CNT_CLR: left_d = '0;
        default: left_d = left_q;
      endcase
      case (ctrl_i.uw.right_op)
        CNT_INC: right_d = right_q + CntW'(1);
        CNT_DEC: right_d = right_q - CntW'(1);
        CNT_CLR: right_d = '0;
        default: right_d = right_q;
      endcase
    end
  end

  // Result flags, cleared when a request is taken
  always_comb begin
    ovf_d = ovf_q;
    inr_d = inr_q;
    if (latch) begin
      ovf_d = 1'b0;
      inr_d = 1'b0;
    end else if (ctrl_i.go) begin
      ovf_d = ovf_q | ctrl_i.uw.set_ovf;
      inr_d = inr_q | ctrl_i.uw.set_inr;
    end
  end

  // Build the result and hold it until taken
  always_comb begin
    out_d.read_char       = inr_q ? rdata_q : '0;
    out_d.in_range        = inr_q;
    out_d.line_length     = LenW'(OutW'(len));
    out_d.cursor_position = LenW'(OutW'(left_q));
    out_d.overflow        = ovf_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      right_q     <= '0;
      ovf_q       <= 1'b0;
      inr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      left_q      <= left_d;
      right_q     <= right_d;
      ovf_q       <= ovf_d;
      inr_q       <= inr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the request and the result payload
  always_ff @(posedge clk_i) begin
    if (latch) begin
      item_q <= in_req_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign status_o.left_zero  = (left_q == '0);
  assign status_o.right_zero = (right_q == '0);
  assign status_o.full       = (len == CntW'(Depth));
  assign status_o.out_range  = !(pos_c < len_c);
  assign status_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_req_o   = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/keystroke_line_editor_unit.sv -----
// Top level of the keystroke line editor: gap buffer line with a cursor.
// Instantiates kle_useq and kle_dpath; types from kle_pkg.
//
//   port group   direction  handshake                 payload
//   in_*         request    in_valid_i / in_ready_o    in_req_i  (kle_req_t)
//   out_*        result     out_valid_o / out_ready_i  out_req_o (kle_rsp_t)
//
// Each request steps through the fetch step, the microcode steps of its
// routine and a final step that loads the result register. A cursor move
// needs a read step and a write step, since the store has a single port.
// Reset clears both counts and the result valid flag; the store is not cleared.
// A pending result stalls only the final step; the next request is taken
// once the sequencer is back at its fetch step.
module keystroke_line_editor_unit #(
  parameter int unsigned Depth = kle_pkg::DepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kle_pkg::kle_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kle_pkg::kle_rsp_t out_req_o
);
  import kle_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Step through the control store
  kle_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // Store, counts and result register
  kle_dpath #(
    .Depth (Depth)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_req_i    (in_req_i),
    .status_o    (status),
    .out_req_o   (out_req_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
